/* hdl/esip_pkg.sv */
// shared types, widths and codes of the encoder speed incremental pid block
package esip_pkg;

  // fixed-point fraction bits and encoder counter width
  localparam int FRACTION_BITS = 8;
  localparam int COUNTER_BITS  = 16;

  // field and register widths
  localparam int COUNT_IN_W = 16;
  localparam int TARGET_W   = 24;
  localparam int SPEED_W    = 32;
  localparam int POS_W      = 32;
  localparam int DRIVE_W    = 11;
  localparam int PWM_W      = 10;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int E_W   = 33;
  localparam int A_W   = E_W + 2;
  localparam int B_W   = GAIN_W + 1;
  localparam int MUL_W = A_W + B_W;
  localparam int SUM_W = MUL_W + 2;
  localparam int ACC_W = LIMIT_W + FRACTION_BITS + 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIRECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_PER_PULSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT      = 3'd5;

  // register reset values
  localparam logic [GAIN_W-1:0]  RST_SPEED_PER_PULSE = 16'd1477;
  localparam logic [GAIN_W-1:0]  RST_GAIN_P          = 16'd1280;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I          = 16'd13;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D          = 16'd26;
  localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT     = 10'd950;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL_SPD,
    ST_SAT,
    ST_DIFF,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_D,
    ST_SUM,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // operand select of the shared multiplier
  typedef enum logic [1:0] {
    MUL_SPEED,
    MUL_INT,
    MUL_PROP,
    MUL_DERIV
  } mul_sel_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic     load;
    logic     delta_step;
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     pos_add;
    logic     sat_speed;
    logic     err_step;
    logic     zero_clear;
    logic     hist_diff;
    logic     sum_load;
    logic     sum_add;
    logic     update;
    logic     out_load;
  } cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic is_tick;
    logic zero_in;
  } sts_t;

endpackage

/* hdl/esip_ctrl.sv */
// sequencer of the encoder speed pid: handshakes and step commands
module esip_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  esip_pkg::sts_t     sts,
  output esip_pkg::cmd_t     cmd
);

  esip_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != esip_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esip_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      esip_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = esip_pkg::ST_DELTA;
        end
      end
      esip_pkg::ST_DELTA: begin
        if (sts.is_tick) begin
          cmd.delta_step = 1'b1;
          state_nxt      = esip_pkg::ST_MUL_SPD;
        end else begin
          cmd.capture = 1'b1;
          state_nxt   = esip_pkg::ST_EMIT;
        end
      end
      esip_pkg::ST_MUL_SPD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = esip_pkg::MUL_SPEED;
        cmd.pos_add = 1'b1;
        state_nxt   = esip_pkg::ST_SAT;
      end
      esip_pkg::ST_SAT: begin
        cmd.sat_speed = 1'b1;
        state_nxt     = esip_pkg::ST_DIFF;
      end
      esip_pkg::ST_DIFF: begin
        if (sts.zero_in) begin
          cmd.zero_clear = 1'b1;
          state_nxt      = esip_pkg::ST_EMIT;
        end else begin
          cmd.err_step = 1'b1;
          state_nxt    = esip_pkg::ST_MUL_I;
        end
      end
      esip_pkg::ST_MUL_I: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = esip_pkg::MUL_INT;
        cmd.hist_diff = 1'b1;
        state_nxt     = esip_pkg::ST_MUL_P;
      end
      esip_pkg::ST_MUL_P: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = esip_pkg::MUL_PROP;
        cmd.sum_load = 1'b1;
        state_nxt    = esip_pkg::ST_MUL_D;
      end
      esip_pkg::ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = esip_pkg::MUL_DERIV;
        cmd.sum_add = 1'b1;
        state_nxt   = esip_pkg::ST_SUM;
      end
      esip_pkg::ST_SUM: begin
        cmd.sum_add = 1'b1;
        state_nxt   = esip_pkg::ST_UPDATE;
      end
      esip_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = esip_pkg::ST_EMIT;
      end
      esip_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = esip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = esip_pkg::ST_IDLE;
      end
    endcase
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending result");

  // an accepted request starts the delta step
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == esip_pkg::ST_DELTA))
    else $error("accepted request did not start the sequence");

  // a finished result waits while the output is stalled
  a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esip_pkg::ST_EMIT && out_valid_r && out_stall)
      |=> (state_r == esip_pkg::ST_EMIT))
    else $error("sequence left emit while output stalled");

  // state-changing commands are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.delta_step, cmd.capture, cmd.sat_speed,
              cmd.err_step, cmd.zero_clear, cmd.update, cmd.out_load}))
    else $error("more than one step command at once");

endmodule

/* hdl/esip_dp.sv */
// datapath of the encoder speed pid: registers, shared multiplier, accumulator
module esip_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [esip_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [esip_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_kind,
  input  logic [esip_pkg::COUNT_IN_W-1:0]        in_encoder_count,
  input  logic signed [esip_pkg::TARGET_W-1:0]   in_target_speed,
  input  esip_pkg::cmd_t                         cmd,
  output esip_pkg::sts_t                         sts,
  output logic signed [esip_pkg::DRIVE_W-1:0]    out_drive,
  output logic [esip_pkg::PWM_W-1:0]             out_pwm_forward,
  output logic [esip_pkg::PWM_W-1:0]             out_pwm_reverse,
  output logic signed [esip_pkg::SPEED_W-1:0]    out_measured_speed,
  output logic signed [esip_pkg::POS_W-1:0]      out_position_total
);

  localparam int CB = esip_pkg::COUNTER_BITS;
  localparam int FB = esip_pkg::FRACTION_BITS;

  // configuration registers
  logic                               invert_r;
  logic [esip_pkg::GAIN_W-1:0]        spp_r, gain_p_r, gain_i_r, gain_d_r;
  logic [esip_pkg::LIMIT_W-1:0]       limit_r;

  // request registers
  logic                               kind_r;
  logic [CB-1:0]                      count_r;
  logic signed [esip_pkg::TARGET_W-1:0] target_r;

  // controller state
  logic [CB-1:0]                      ref_r;
  logic signed [esip_pkg::POS_W-1:0]  pulse_r;
  logic signed [esip_pkg::SPEED_W-1:0] speed_r;
  logic signed [esip_pkg::ACC_W-1:0]  acc_r;
  logic signed [esip_pkg::E_W-1:0]    e1_r, e2_r;

  // working registers
  logic signed [CB-1:0]               delta_r;
  logic signed [esip_pkg::E_W-1:0]    e_r;
  logic signed [esip_pkg::A_W-1:0]    de1_r, dd_r;
  logic signed [esip_pkg::MUL_W-1:0]  prod_r;
  logic signed [esip_pkg::SUM_W-1:0]  sum_r;

  // result registers
  logic signed [esip_pkg::DRIVE_W-1:0] drive_r;
  logic [esip_pkg::PWM_W-1:0]          fwd_r, rev_r;
  logic signed [esip_pkg::SPEED_W-1:0] meas_r;
  logic signed [esip_pkg::POS_W-1:0]   pos_r;

  // combinational helpers
  logic [CB-1:0]                      raw_diff, delta_nxt;
  logic signed [esip_pkg::A_W-1:0]    mul_a;
  logic signed [esip_pkg::B_W-1:0]    mul_b;
  logic                               spd_ovf;
  logic signed [esip_pkg::SPEED_W-1:0] speed_nxt;
  logic signed [esip_pkg::SUM_W-1:0]  inc, acc_wide, lim_w, acc_cl;
  logic signed [esip_pkg::ACC_W-1:0]  mag, mag_int;

  assign sts.is_tick = kind_r;
  assign sts.zero_in = (target_r == '0) && (speed_r == '0);

  // wrapped and optionally negated encoder delta
  assign raw_diff  = count_r - ref_r;
  assign delta_nxt = invert_r ? (CB'(0) - raw_diff) : raw_diff;

  // operand select of the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      esip_pkg::MUL_SPEED: begin
        mul_a = esip_pkg::A_W'(delta_r);
        mul_b = signed'({1'b0, spp_r});
      end
      esip_pkg::MUL_INT: begin
        mul_a = esip_pkg::A_W'(e_r);
        mul_b = signed'({1'b0, gain_i_r});
      end
      esip_pkg::MUL_PROP: begin
        mul_a = de1_r;
        mul_b = signed'({1'b0, gain_p_r});
      end
      esip_pkg::MUL_DERIV: begin
        mul_a = dd_r;
        mul_b = signed'({1'b0, gain_d_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // speed saturation to 32 bits
  assign spd_ovf   = (prod_r[esip_pkg::MUL_W-1:esip_pkg::SPEED_W-1]
                      != {(esip_pkg::MUL_W-esip_pkg::SPEED_W+1){prod_r[esip_pkg::MUL_W-1]}});
  assign speed_nxt = !spd_ovf ? prod_r[esip_pkg::SPEED_W-1:0] :
                     (prod_r[esip_pkg::MUL_W-1] ? {1'b1, {(esip_pkg::SPEED_W-1){1'b0}}}
                                                : {1'b0, {(esip_pkg::SPEED_W-1){1'b1}}});

  // floor shift, accumulate and clamp
  assign inc      = sum_r >>> FB;
  assign acc_wide = esip_pkg::SUM_W'(acc_r) + inc;
  assign lim_w    = signed'(esip_pkg::SUM_W'(limit_r) << FB);
  always_comb begin
    if (acc_wide > lim_w) begin
      acc_cl = lim_w;
    end else if (acc_wide < -lim_w) begin
      acc_cl = -lim_w;
    end else begin
      acc_cl = acc_wide;
    end
  end

  // integer part of the drive, truncated toward zero
  assign mag     = acc_r[esip_pkg::ACC_W-1] ? -acc_r : acc_r;
  assign mag_int = mag >>> FB;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
      spp_r    <= esip_pkg::RST_SPEED_PER_PULSE;
      gain_p_r <= esip_pkg::RST_GAIN_P;
      gain_i_r <= esip_pkg::RST_GAIN_I;
      gain_d_r <= esip_pkg::RST_GAIN_D;
      limit_r  <= esip_pkg::RST_DRIVE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        esip_pkg::REG_INVERT_DIRECTION: invert_r <= cfg_wdata[0];
        esip_pkg::REG_SPEED_PER_PULSE:  spp_r    <= cfg_wdata;
        esip_pkg::REG_GAIN_P:           gain_p_r <= cfg_wdata;
        esip_pkg::REG_GAIN_I:           gain_i_r <= cfg_wdata;
        esip_pkg::REG_GAIN_D:           gain_d_r <= cfg_wdata;
        esip_pkg::REG_DRIVE_LIMIT:      limit_r  <= cfg_wdata[esip_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // loop state: reference, position, speed, accumulator, error history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= '0;
      pulse_r <= '0;
      speed_r <= '0;
      acc_r   <= '0;
      e1_r    <= '0;
      e2_r    <= '0;
    end else begin
      if (cmd.delta_step || cmd.capture) begin
        ref_r <= count_r;
      end
      if (cmd.capture) begin
        speed_r <= '0;
      end else if (cmd.sat_speed) begin
        speed_r <= speed_nxt;
      end
      if (cmd.pos_add) begin
        pulse_r <= pulse_r + esip_pkg::POS_W'(delta_r);
      end
      if (cmd.capture || cmd.zero_clear) begin
        acc_r <= '0;
        e1_r  <= '0;
        e2_r  <= '0;
      end else if (cmd.update) begin
        acc_r <= esip_pkg::ACC_W'(acc_cl);
        e1_r  <= e_r;
        e2_r  <= e1_r;
      end
    end
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      count_r  <= CB'(in_encoder_count);
      target_r <= in_target_speed;
    end
    if (cmd.delta_step) begin
      delta_r <= signed'(delta_nxt);
    end
    if (cmd.err_step) begin
      e_r <= esip_pkg::E_W'(target_r) - esip_pkg::E_W'(speed_r);
    end
    if (cmd.hist_diff) begin
      de1_r <= esip_pkg::A_W'(e_r) - esip_pkg::A_W'(e1_r);
      dd_r  <= esip_pkg::A_W'(e_r) - (esip_pkg::A_W'(e1_r) <<< 1) + esip_pkg::A_W'(e2_r);
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.sum_load) begin
      sum_r <= esip_pkg::SUM_W'(prod_r);
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + esip_pkg::SUM_W'(prod_r);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
      fwd_r   <= '0;
      rev_r   <= '0;
      meas_r  <= '0;
      pos_r   <= '0;
    end else if (cmd.out_load) begin
      drive_r <= acc_r[esip_pkg::ACC_W-1] ? -esip_pkg::DRIVE_W'(mag_int)
                                          : esip_pkg::DRIVE_W'(mag_int);
      fwd_r   <= (!acc_r[esip_pkg::ACC_W-1]) ? mag_int[esip_pkg::PWM_W-1:0] : '0;
      rev_r   <= acc_r[esip_pkg::ACC_W-1] ? mag_int[esip_pkg::PWM_W-1:0] : '0;
      meas_r  <= speed_r;
      pos_r   <= pulse_r;
    end
  end

  assign out_drive          = drive_r;
  assign out_pwm_forward    = fwd_r;
  assign out_pwm_reverse    = rev_r;
  assign out_measured_speed = meas_r;
  assign out_position_total = pos_r;

  // accumulator stays inside the drive limit after an update
  a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> ((esip_pkg::SUM_W'(acc_r) <= lim_w) && (esip_pkg::SUM_W'(acc_r) >= -lim_w)))
    else $error("drive accumulator outside limit");

  // capture and zero-speed cases leave the pid cleared
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.capture || cmd.zero_clear) |=> (acc_r == '0 && e1_r == '0 && e2_r == '0))
    else $error("pid state not cleared");

  // pwm channels are never both active
  a_pwm_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (fwd_r == '0) || (rev_r == '0))
    else $error("both pwm channels active");

endmodule

/* hdl/encoder_speed_incremental_pid_top.sv */
// top level of the encoder speed incremental pid controller
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_kind, in_encoder_count, in_target_speed
//  out      output     out_valid/out_stall  out_drive, out_pwm_forward, out_pwm_reverse,
//                                           out_measured_speed, out_position_total
//  cfg      input      cfg_we               cfg_index, cfg_wdata
//
// a control tick runs every step from delta to update, a capture only delta and a
// standstill tick with zero target up to the error check, before the output register
// loads; the shared 35x17 multiplier forms the four products in turn; one request at
// a time: a new one can be taken in the cycle after the previous result reaches the
// output register; a stalled result holds there and the sequencer waits in emit
// synchronous active-low reset clears the loop state and loads register defaults
module encoder_speed_incremental_pid_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [esip_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [esip_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_kind,
  input  logic [esip_pkg::COUNT_IN_W-1:0]        in_encoder_count,
  input  logic signed [esip_pkg::TARGET_W-1:0]   in_target_speed,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [esip_pkg::DRIVE_W-1:0]    out_drive,
  output logic [esip_pkg::PWM_W-1:0]             out_pwm_forward,
  output logic [esip_pkg::PWM_W-1:0]             out_pwm_reverse,
  output logic signed [esip_pkg::SPEED_W-1:0]    out_measured_speed,
  output logic signed [esip_pkg::POS_W-1:0]      out_position_total
);

  esip_pkg::cmd_t cmd;
  esip_pkg::sts_t sts;

  // sequencer
  esip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  esip_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_kind            (in_kind),
    .in_encoder_count   (in_encoder_count),
    .in_target_speed    (in_target_speed),
    .cmd                (cmd),
    .sts                (sts),
    .out_drive          (out_drive),
    .out_pwm_forward    (out_pwm_forward),
    .out_pwm_reverse    (out_pwm_reverse),
    .out_measured_speed (out_measured_speed),
    .out_position_total (out_position_total)
  );

endmodule
